FILE: rtl/srl_pkg.sv
// Shared types and constants for the sequential record list.
// Used by sequential_record_list_top and the testbench; no dependencies.
package srl_pkg;

  localparam int unsigned DEPTH        = 128;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned IDX_W        = $clog2(DEPTH);
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned COUNT_W      = 8;
  localparam int unsigned IN_DATA_W    = 72;
  localparam int unsigned OUT_DATA_W   = 80;
  localparam int unsigned ENTRY_W      = KEY_W + PAYLOAD_BITS;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND    = 3'd0,
    MODE_FRONT     = 3'd1,
    MODE_SORTED    = 3'd2,
    MODE_REM_LAST  = 3'd3,
    MODE_REM_FIRST = 3'd4,
    MODE_REM_KEY   = 3'd5,
    MODE_READ_POS  = 3'd6,
    MODE_FIND_KEY  = 3'd7
  } mode_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_UP    = 7'b0000100,
    S_DOWN  = 7'b0001000,
    S_FETCH = 7'b0010000,
    S_LATCH = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [31:0]      record_payload;
    logic [KEY_W-1:0] record_key;
  } in_data_t;

  typedef struct packed {
    logic [4:0]         pad;
    logic               is_empty;
    logic               is_full;
    logic [COUNT_W-1:0] count;
    logic [31:0]        found_payload;
    logic [KEY_W-1:0]   found_key;
    logic               ok;
  } out_data_t;

endpackage

FILE: rtl/srl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module srl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sequential_record_list_top.sv
// Top level of the sequential record list: sequencer, result register.
// Depends on srl_pkg and srl_ram.
//
// A bounded sorted/unsorted list of up to DEPTH records (signed key plus payload) held in
// one RAM. One item runs one operation; the block takes a new item only while idle, and
// the result waits in an output register so the next item can start before it is taken.
// Every record moves through the one RAM read port, one entry per cycle: remove last,
// failed inserts and bad reads go straight to S_DONE, a position read passes through
// S_FETCH and S_LATCH, and searches and shifts walk the list entry by entry.
module sequential_record_list_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // record_key[31:0], record_payload[63:32], position[71:64]
  input  logic [srl_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // mode[2:0]
  input  logic [srl_pkg::MODE_W-1:0]         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // ok[0], found_key[32:1], found_payload[64:33], count[72:65], is_full[73],
  // is_empty[74], zero[79:75]
  output logic [srl_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);
  import srl_pkg::*;

  state_e                  state_q, state_d;
  mode_e                   op_q, op_d;
  logic [KEY_W-1:0]        key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]        slot_q, slot_d;
  logic [IDX_W-1:0]        wr_addr_q, wr_addr_d;
  logic                    live_q, live_d;
  logic                    res_ok_q, res_ok_d;
  entry_t                  res_q, res_d;
  logic                    m_valid_q, m_valid_d;
  out_data_t               m_data_q, m_data_d;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  entry_t                  ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  entry_t                  ram_rdata;

  in_data_t                in_data;
  mode_e                   in_mode;
  logic                    hit;

  assign in_data = in_data_t'(s_axis_tdata_i);
  assign in_mode = mode_e'(s_axis_tuser_i);

  srl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (op_q == MODE_SORTED) begin
      hit = $signed(ram_rdata.key) >= $signed(key_q);
    end else begin
      hit = ram_rdata.key == key_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    pay_d     = pay_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    wr_addr_d = wr_addr_q;
    live_d    = 1'b0;
    res_ok_d  = res_ok_q;
    res_d     = res_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_waddr = wr_addr_q;
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = in_mode;
          key_d    = in_data.record_key;
          pay_d    = in_data.record_payload[PAYLOAD_BITS-1:0];
          res_ok_d = 1'b0;
          res_d    = '0;
          state_d  = S_DONE;
          unique case (in_mode)
            MODE_APPEND, MODE_FRONT: begin
              if (cnt_q != CNT_W'(DEPTH)) begin
                slot_d  = (in_mode == MODE_APPEND) ? cnt_q : '0;
                idx_d   = cnt_q;
                state_d = S_UP;
              end
            end
            MODE_SORTED: begin
              if (cnt_q != CNT_W'(DEPTH)) begin
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            MODE_REM_LAST: begin
              if (cnt_q != '0) begin
                cnt_d    = cnt_q - 1'b1;
                res_ok_d = 1'b1;
              end
            end
            MODE_REM_FIRST: begin
              if (cnt_q != '0) begin
                idx_d   = CNT_W'(1);
                state_d = S_DOWN;
              end
            end
            MODE_REM_KEY, MODE_FIND_KEY: begin
              idx_d   = '0;
              state_d = S_SCAN;
            end
            MODE_READ_POS: begin
              if (in_data.position != '0 && in_data.position <= POS_W'(cnt_q)) begin
                idx_d   = CNT_W'(in_data.position - 1'b1);
                state_d = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (idx_q < cnt_q) begin
          live_d    = 1'b1;
          wr_addr_d = idx_q[IDX_W-1:0];
          idx_d     = idx_q + 1'b1;
        end
        if (live_q && hit) begin
          live_d = 1'b0;
          slot_d = CNT_W'(wr_addr_q);
          priority case (op_q)
            MODE_SORTED: begin
              idx_d   = cnt_q;
              state_d = S_UP;
            end
            MODE_REM_KEY: begin
              idx_d   = CNT_W'(wr_addr_q) + 1'b1;
              state_d = S_DOWN;
            end
            default: begin
              res_ok_d = 1'b1;
              res_d    = ram_rdata;
              state_d  = S_DONE;
            end
          endcase
        end else if (!live_q && idx_q >= cnt_q) begin
          if (op_q == MODE_SORTED) begin
            slot_d  = cnt_q;
            idx_d   = cnt_q;
            state_d = S_UP;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_UP: begin
        if (live_q) begin
          ram_we = 1'b1;
        end
        if (idx_q > slot_q) begin
          ram_raddr = IDX_W'(idx_q - 1'b1);
          live_d    = 1'b1;
          wr_addr_d = idx_q[IDX_W-1:0];
          idx_d     = idx_q - 1'b1;
        end else if (!live_q) begin
          ram_we    = 1'b1;
          ram_waddr = slot_q[IDX_W-1:0];
          ram_wdata = '{key: key_q, payload: pay_q};
          cnt_d     = cnt_q + 1'b1;
          res_ok_d  = 1'b1;
          state_d   = S_DONE;
        end
      end

      S_DOWN: begin
        if (live_q) begin
          ram_we = 1'b1;
        end
        if (idx_q < cnt_q) begin
          live_d    = 1'b1;
          wr_addr_d = idx_q[IDX_W-1:0] - 1'b1;
          idx_d     = idx_q + 1'b1;
        end else if (!live_q) begin
          cnt_d    = cnt_q - 1'b1;
          res_ok_d = 1'b1;
          state_d  = S_DONE;
        end
      end

      S_FETCH: begin
        state_d = S_LATCH;
      end

      S_LATCH: begin
        res_ok_d = 1'b1;
        res_d    = ram_rdata;
        state_d  = S_DONE;
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d              = 1'b1;
          m_data_d.pad           = '0;
          m_data_d.ok            = res_ok_q;
          m_data_d.found_key     = res_q.key;
          m_data_d.found_payload = 32'(res_q.payload);
          m_data_d.count         = COUNT_W'(cnt_q);
          m_data_d.is_full       = cnt_q == CNT_W'(DEPTH);
          m_data_d.is_empty      = cnt_q == '0;
          state_d                = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      live_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      live_q    <= live_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    pay_q     <= pay_d;
    idx_q     <= idx_d;
    slot_q    <= slot_d;
    wr_addr_q <= wr_addr_d;
    res_ok_q  <= res_ok_d;
    res_q     <= res_d;
    m_data_q  <= m_data_d;
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for sequential_record_list_top: streams list operations
// and checks every reply against a predicted copy of the record list.
// Depends on srl_pkg and the RTL of sequential_record_list_top only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import srl_pkg::*;

  class record_list_scoreboard;
    logic [KEY_W-1:0] keys [DEPTH];
    logic [31:0]      payloads [DEPTH];
    int               fill;
    out_data_t        pending_replies [$];
    int               mismatches;
    int               replies_checked;
    int               items_applied;
    int               items_refused;
    int               times_full;
    int               times_empty;

    function new();
      fill = 0;
      mismatches = 0;
      replies_checked = 0;
      items_applied = 0;
      items_refused = 0;
      times_full = 0;
      times_empty = 0;
    endfunction

    // Apply one accepted operation to the list copy and queue the reply it yields.
    function void apply_operation(mode_e mode, logic [KEY_W-1:0] key, logic [31:0] payload,
                                  logic [POS_W-1:0] position);
      out_data_t reply;
      int        slot;
      reply = '0;
      slot = 0;
      case (mode)
        MODE_APPEND, MODE_FRONT, MODE_SORTED: begin
          if (fill < DEPTH) begin
            if (mode == MODE_APPEND) begin
              slot = fill;
            end else if (mode == MODE_SORTED) begin
              while (slot < fill && $signed(keys[slot]) < $signed(key)) slot = slot + 1;
            end
            for (int k = fill; k > slot; k--) begin
              keys[k] = keys[k-1];
              payloads[k] = payloads[k-1];
            end
            keys[slot] = key;
            payloads[slot] = payload;
            fill = fill + 1;
            reply.ok = 1'b1;
          end
        end
        MODE_REM_LAST: begin
          if (fill > 0) begin
            fill = fill - 1;
            reply.ok = 1'b1;
          end
        end
        MODE_REM_FIRST, MODE_REM_KEY: begin
          if (mode == MODE_REM_KEY) begin
            while (slot < fill && keys[slot] != key) slot = slot + 1;
          end
          if (slot < fill) begin
            for (int k = slot; k + 1 < fill; k++) begin
              keys[k] = keys[k+1];
              payloads[k] = payloads[k+1];
            end
            fill = fill - 1;
            reply.ok = 1'b1;
          end
        end
        MODE_READ_POS: begin
          if (position >= 1 && position <= fill) begin
            reply.found_key = keys[position-1];
            reply.found_payload = payloads[position-1];
            reply.ok = 1'b1;
          end
        end
        default: begin
          while (slot < fill && keys[slot] != key) slot = slot + 1;
          if (slot < fill) begin
            reply.found_key = keys[slot];
            reply.found_payload = payloads[slot];
            reply.ok = 1'b1;
          end
        end
      endcase
      reply.count = COUNT_W'(fill);
      reply.is_full = (fill == DEPTH);
      reply.is_empty = (fill == 0);
      items_applied++;
      if (!reply.ok) items_refused++;
      if (reply.is_full) times_full++;
      if (reply.is_empty) times_empty++;
      pending_replies.push_back(reply);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_reply(out_data_t got);
      out_data_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with no item outstanding", got[31:0], '0);
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
        if (got.found_key !== want.found_key)
          report_mismatch("found_key", got.found_key, want.found_key);
        if (got.found_payload !== want.found_payload)
          report_mismatch("found_payload", got.found_payload, want.found_payload);
        if (got.count !== want.count) report_mismatch("count", got.count, want.count);
        if (got.is_full !== want.is_full) report_mismatch("is_full", got.is_full, want.is_full);
        if (got.is_empty !== want.is_empty)
          report_mismatch("is_empty", got.is_empty, want.is_empty);
        if (got.pad !== want.pad) report_mismatch("zero fill", got.pad, want.pad);
      end
    endtask
  endclass

  localparam int RANDOM_ITEMS = 1650;
  localparam int PHASE_LEN    = 250;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 200;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [MODE_W-1:0]     s_tuser;
  logic                  m_axis_tvalid_o;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  logic                  no_gaps;
  int                    quiet_cycles = 0;

  record_list_scoreboard sb = new();

  sequential_record_list_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(mode_e mode, logic [KEY_W-1:0] key, logic [31:0] payload,
                           logic [POS_W-1:0] position);
    while (!no_gaps && $urandom_range(0, 99) < 36) begin
      s_tvalid <= 1'b0;
      s_tdata <= IN_DATA_W'({$urandom, $urandom, $urandom});
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {position, payload, key};
    s_tuser <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.apply_operation(mode, key, payload, position);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_tready <= no_gaps || ($urandom_range(0, 99) >= 36);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) sb.check_reply(out_data_t'(m_axis_tdata_o));
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("sequential_record_list_top verification failed");
      $finish;
    end
  end

  initial begin
    mode_e            mode;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
    int               phase;
    int               roll;
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    no_gaps = 1'b0;
    phase = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(MODE_REM_LAST, '0, '0, '0);
    send_item(MODE_REM_FIRST, '0, '0, '0);
    send_item(MODE_REM_KEY, 32'd5, '0, '0);
    send_item(MODE_READ_POS, '0, '0, 8'd1);
    send_item(MODE_FIND_KEY, '0, '0, '0);
    send_item(MODE_APPEND, 32'h7fff_ffff, 32'hffff_ffff, 8'hff);
    send_item(MODE_FRONT, 32'h8000_0000, 32'h0000_0000, '0);
    send_item(MODE_SORTED, 32'd0, 32'ha5a5_a5a5, '0);
    send_item(MODE_SORTED, 32'd0, 32'h5a5a_5a5a, '0);
    send_item(MODE_SORTED, 32'hffff_ffff, 32'h1234_5678, '0);
    send_item(MODE_SORTED, 32'h7fff_ffff, 32'h8765_4321, '0);
    send_item(MODE_READ_POS, '0, '0, 8'd0);
    send_item(MODE_READ_POS, '0, '0, 8'd1);
    send_item(MODE_READ_POS, '0, '0, 8'd6);
    send_item(MODE_READ_POS, '0, '0, 8'd7);
    send_item(MODE_READ_POS, '0, '0, 8'hff);
    send_item(MODE_FIND_KEY, 32'd0, '0, '0);
    send_item(MODE_FIND_KEY, 32'd12345, '0, '0);
    send_item(MODE_REM_KEY, 32'd0, '0, '0);
    send_item(MODE_REM_KEY, 32'd999, '0, '0);
    send_item(MODE_REM_FIRST, '0, '0, '0);
    send_item(MODE_REM_LAST, '0, '0, '0);
    send_item(MODE_FIND_KEY, 32'h7fff_ffff, '0, '0);

    // Phases cycle through growing to full, draining to empty, and a uniform mix.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        wait_drained();
        phase = (n / PHASE_LEN) % 3;
        no_gaps = (n / PHASE_LEN == 3);
      end
      roll = $urandom_range(0, 99);
      if (phase == 2) begin
        mode = mode_e'($urandom_range(0, 7));
      end else if (roll < (phase == 0 ? 80 : 10)) begin
        mode = mode_e'($urandom_range(0, 2));
      end else if (roll < (phase == 0 ? 90 : 85)) begin
        mode = mode_e'($urandom_range(3, 5));
      end else begin
        mode = mode_e'($urandom_range(6, 7));
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        key = KEY_W'($urandom_range(0, 16)) - 32'd8;
      end else if (roll < 75) begin
        case ($urandom_range(0, 3))
          0: key = 32'h8000_0000;
          1: key = 32'h7fff_ffff;
          2: key = 32'hffff_ffff;
          default: key = '0;
        endcase
      end else begin
        key = $urandom;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        position = POS_W'($urandom_range(1, sb.fill + 1));
      end else if (roll < 80) begin
        position = '0;
      end else begin
        position = POS_W'($urandom_range(0, 255));
      end
      send_item(mode, key, $urandom, position);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending_replies.size() != 0)
      sb.report_mismatch("replies never returned", sb.pending_replies.size(), 0);
    $display("covered %0d list operations, %0d refused (full, empty, miss or bad position)",
             sb.items_applied, sb.items_refused);
    $display("checked %0d replies; list stood full after %0d items and empty after %0d",
             sb.replies_checked, sb.times_full, sb.times_empty);
    if (sb.mismatches == 0) begin
      $display("sequential_record_list_top verification clean");
    end else begin
      $display("sequential_record_list_top verification failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/srl_pkg.sv
rtl/srl_ram.sv
rtl/sequential_record_list_top.sv
dv/testbench.sv
